/* rtl/core/id3v2_tag_frame_walker_macros.svh */
// Assertion macros for the ID3v2 tag frame walker.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef ID3V2_TAG_FRAME_WALKER_MACROS_SVH
`define ID3V2_TAG_FRAME_WALKER_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ID3FW_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define ID3FW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/id3fw_pkg.sv */
// Types, codes and constants of the ID3v2 tag frame walker.
// No dependencies.
package id3fw_pkg;

	typedef enum logic [1:0] {
		KIND_TAG     = 2'd0,
		KIND_FRAME   = 2'd1,
		KIND_PAYLOAD = 2'd2,
		KIND_STATUS  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_TAG   = 3'd1,
		ST_BAD_EXT   = 3'd2,
		ST_BAD_FRAME = 3'd3,
		ST_TOO_BIG   = 3'd4
	} status_t;

	localparam logic [7:0] CHAR_I    = 8'h49;
	localparam logic [7:0] CHAR_D    = 8'h44;
	localparam logic [7:0] CHAR_3    = 8'h33;
	localparam logic [7:0] SYNC_BYTE = 8'hFF;

	localparam int TAG_FLAG_UNSYNC_BIT   = 7;
	localparam int TAG_FLAG_EXT_BIT      = 6;
	localparam int FRAME_FLAG_UNSYNC_BIT = 1;

	localparam logic [3:0] TAG_HDR_LAST   = 4'd9;
	localparam logic [3:0] EXT_SIZE_LAST  = 4'd3;
	localparam logic [3:0] LONG_HDR_LEN   = 4'd10;
	localparam logic [3:0] SHORT_HDR_LEN  = 4'd6;
	localparam logic [7:0] SHORT_VERSION  = 8'd2;
	localparam logic [7:0] PLAIN_VERSION  = 8'd3;
	localparam logic [27:0] EXT_SIZE_BYTES = 28'd4;

	localparam int OUT_DATA_W = 104;

	function automatic logic id_char_ok(input logic [7:0] b);
		return b inside {[8'h41:8'h5A], [8'h30:8'h39]};
	endfunction

endpackage

/* rtl/core/id3v2_tag_frame_walker.sv */
// Top level of the ID3v2 tag frame walker: header check, unsync removal, frame walk.
// Depends on id3fw_pkg and id3v2_tag_frame_walker_macros.svh.
//
//   channel   direction  tdata                       tuser       tlast
//   s_axis    in         data_byte                   start_req   -
//   m_axis    out        version,id,size,flags,byte  kind        frame_last
//
// One byte per cycle unless m_axis stalls: an input register, then the parse step,
// then a result register, through which each result reaches m_axis.
// A byte that yields no result moves on even while the result register is full.
// arst_n clears the control state; the parser then waits for a start byte.
// A stall on m_axis holds the input register and then s_axis_tready.
`include "id3v2_tag_frame_walker_macros.svh"

module id3v2_tag_frame_walker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
	input  logic                              s_axis_tuser,   // [0] start_req
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] major_version, [39:8] item_id, [71:40] item_size, [87:72] item_flags,
	// [95:88] payload_byte, [98:96] status, [103:99] zero
	output logic [id3fw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic [1:0]                        m_axis_tuser,   // [1:0] kind
	output logic                              m_axis_tlast    // frame_last
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TAGHDR,
		PH_EXTSIZE,
		PH_EXTSKIP,
		PH_FRHDR,
		PH_PAYLOAD
	} phase_t;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        advance;

	phase_t      phase_q;
	logic [3:0]  cnt_q;
	logic [31:0] id_q;
	logic [31:0] size_q;
	logic [15:0] flags_q;
	logic [7:0]  ver_q;
	logic [7:0]  tflags_q;
	logic [27:0] tag_rem_q;
	logic [27:0] skip_q;
	logic [31:0] frame_rem_q;
	logic        tag_ff_q;
	logic        frame_ff_q;

	phase_t      cur_phase;
	logic [3:0]  cur_cnt;
	logic [31:0] cur_id;
	logic [31:0] cur_size;
	logic [15:0] cur_flags;
	logic [7:0]  cur_ver;
	logic [7:0]  cur_tflags;
	logic [27:0] cur_tag_rem;
	logic [27:0] cur_skip;
	logic [31:0] cur_frame_rem;
	logic        cur_tag_ff;
	logic        cur_frame_ff;

	phase_t      n_phase;
	logic [3:0]  n_cnt;
	logic [31:0] n_id;
	logic [31:0] n_size;
	logic [15:0] n_flags;
	logic [7:0]  n_ver;
	logic [7:0]  n_tflags;
	logic [27:0] n_tag_rem;
	logic [27:0] n_skip;
	logic [31:0] n_frame_rem;
	logic        n_tag_ff;
	logic        n_frame_ff;

	logic                 shortform;
	logic [3:0]           hdr_last;
	logic [3:0]           idlen;
	logic [3:0]           size_end;
	logic [3:0]           hdr_len;
	logic                 hdr_err;
	logic                 dropped;
	logic                 do_begin;
	logic                 do_finish;
	logic                 pay_last;
	logic [27:0]          ext;
	logic [27:0]          take;
	id3fw_pkg::status_t   fin_status;

	logic                 res_valid;
	id3fw_pkg::kind_t     res_kind;
	logic [31:0]          res_id;
	logic [31:0]          res_size;
	logic [15:0]          res_flags;
	logic [7:0]           res_pay;
	logic                 res_last;
	id3fw_pkg::status_t   res_status;

	logic                 valid_s2;
	id3fw_pkg::kind_t     kind_s2;
	logic [7:0]           ver_s2;
	logic [31:0]          id_s2;
	logic [31:0]          size_s2;
	logic [15:0]          flags_s2;
	logic [7:0]           pay_s2;
	logic                 last_s2;
	id3fw_pkg::status_t   status_s2;

	assign advance       = valid_s1 && (!res_valid || !valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// start byte restarts from a cleared state
	assign cur_phase     = start_s1 ? PH_TAGHDR : phase_q;
	assign cur_cnt       = start_s1 ? 4'd0  : cnt_q;
	assign cur_id        = start_s1 ? 32'd0 : id_q;
	assign cur_size      = start_s1 ? 32'd0 : size_q;
	assign cur_flags     = start_s1 ? 16'd0 : flags_q;
	assign cur_ver       = start_s1 ? 8'd0  : ver_q;
	assign cur_tflags    = start_s1 ? 8'd0  : tflags_q;
	assign cur_tag_rem   = start_s1 ? 28'd0 : tag_rem_q;
	assign cur_skip      = start_s1 ? 28'd0 : skip_q;
	assign cur_frame_rem = start_s1 ? 32'd0 : frame_rem_q;
	assign cur_tag_ff    = start_s1 ? 1'b0  : tag_ff_q;
	assign cur_frame_ff  = start_s1 ? 1'b0  : frame_ff_q;

	assign shortform = (cur_ver == id3fw_pkg::SHORT_VERSION);
	assign hdr_len   = shortform ? id3fw_pkg::SHORT_HDR_LEN : id3fw_pkg::LONG_HDR_LEN;
	assign hdr_last  = hdr_len - 4'd1;
	assign idlen     = shortform ? 4'd3 : 4'd4;
	assign size_end  = shortform ? 4'd6 : 4'd8;

	always_comb begin
		n_phase     = cur_phase;
		n_cnt       = cur_cnt;
		n_id        = cur_id;
		n_size      = cur_size;
		n_flags     = cur_flags;
		n_ver       = cur_ver;
		n_tflags    = cur_tflags;
		n_tag_rem   = cur_tag_rem;
		n_skip      = cur_skip;
		n_frame_rem = cur_frame_rem;
		n_tag_ff    = cur_tag_ff;
		n_frame_ff  = cur_frame_ff;
		hdr_err     = 1'b0;
		dropped     = 1'b0;
		do_begin    = 1'b0;
		do_finish   = 1'b0;
		pay_last    = 1'b0;
		ext         = 28'd0;
		take        = 28'd0;
		fin_status  = id3fw_pkg::ST_OK;
		res_valid   = 1'b0;
		res_kind    = id3fw_pkg::KIND_TAG;
		res_id      = 32'd0;
		res_size    = 32'd0;
		res_flags   = 16'd0;
		res_pay     = 8'd0;
		res_last    = 1'b0;
		res_status  = id3fw_pkg::ST_OK;

		case (cur_phase)
			PH_TAGHDR: begin
				hdr_err = (cur_cnt == 4'd0 && byte_s1 != id3fw_pkg::CHAR_I) ||
					(cur_cnt == 4'd1 && byte_s1 != id3fw_pkg::CHAR_D) ||
					(cur_cnt == 4'd2 && byte_s1 != id3fw_pkg::CHAR_3) ||
					((cur_cnt == 4'd3 || cur_cnt == 4'd4) &&
						byte_s1 == id3fw_pkg::SYNC_BYTE) ||
					(cur_cnt >= 4'd6 && byte_s1[7]);
				if (hdr_err) begin
					do_finish  = 1'b1;
					fin_status = id3fw_pkg::ST_BAD_TAG;
				end else begin
					if (cur_cnt == 4'd3)
						n_ver = byte_s1;
					else if (cur_cnt == 4'd5)
						n_tflags = byte_s1;
					else if (cur_cnt >= 4'd6)
						n_size = {cur_size[24:0], byte_s1[6:0]};
					if (cur_cnt < id3fw_pkg::TAG_HDR_LAST) begin
						n_cnt = cur_cnt + 4'd1;
					end else begin
						n_tag_rem = n_size[27:0];
						do_begin  = 1'b1;
						res_valid = 1'b1;
						res_kind  = id3fw_pkg::KIND_TAG;
						res_size  = {4'd0, n_tag_rem};
						res_flags = {8'd0, n_tflags};
					end
				end
			end
			PH_EXTSIZE: begin
				if (byte_s1[7]) begin
					do_finish  = 1'b1;
					fin_status = id3fw_pkg::ST_BAD_EXT;
				end else begin
					n_size = {cur_size[24:0], byte_s1[6:0]};
					if (cur_cnt < id3fw_pkg::EXT_SIZE_LAST) begin
						n_cnt = cur_cnt + 4'd1;
					end else begin
						ext = n_size[27:0];
						if (ext > cur_tag_rem) begin
							do_finish  = 1'b1;
							fin_status = id3fw_pkg::ST_BAD_EXT;
						end else begin
							take      = (ext < id3fw_pkg::EXT_SIZE_BYTES) ?
								id3fw_pkg::EXT_SIZE_BYTES : ext;
							n_tag_rem = (take > cur_tag_rem) ? 28'd0 : cur_tag_rem - take;
							n_skip    = (ext > id3fw_pkg::EXT_SIZE_BYTES) ?
								ext - id3fw_pkg::EXT_SIZE_BYTES : 28'd0;
							if (n_skip != 28'd0)
								n_phase = PH_EXTSKIP;
							else
								do_begin = 1'b1;
						end
					end
				end
			end
			PH_EXTSKIP: begin
				n_skip = (cur_skip != 28'd0) ? cur_skip - 28'd1 : 28'd0;
				if (n_skip == 28'd0)
					do_begin = 1'b1;
			end
			PH_FRHDR, PH_PAYLOAD: begin
				if (cur_phase == PH_FRHDR && cur_cnt == 4'd0 &&
					cur_tag_rem <= {24'd0, hdr_len}) begin
					do_finish  = 1'b1;
					fin_status = id3fw_pkg::ST_OK;
				end else begin
					n_tag_rem = (cur_tag_rem != 28'd0) ? cur_tag_rem - 28'd1 : 28'd0;
					if (cur_tflags[id3fw_pkg::TAG_FLAG_UNSYNC_BIT]) begin
						if (cur_tag_ff && byte_s1 == 8'd0) begin
							n_tag_ff = 1'b0;
							dropped  = 1'b1;
						end else begin
							n_tag_ff = (byte_s1 == id3fw_pkg::SYNC_BYTE);
						end
					end
					if (!dropped && cur_phase == PH_FRHDR) begin
						if (cur_cnt < idlen) begin
							if (!id3fw_pkg::id_char_ok(byte_s1)) begin
								do_finish  = 1'b1;
								fin_status = id3fw_pkg::ST_BAD_FRAME;
							end else begin
								n_id = {cur_id[23:0], byte_s1};
							end
						end else if (cur_cnt < size_end) begin
							if (shortform || cur_ver == id3fw_pkg::PLAIN_VERSION) begin
								n_size = {cur_size[23:0], byte_s1};
							end else if (byte_s1[7]) begin
								do_finish  = 1'b1;
								fin_status = id3fw_pkg::ST_BAD_FRAME;
							end else begin
								n_size = {cur_size[24:0], byte_s1[6:0]};
							end
						end else begin
							n_flags = {cur_flags[7:0], byte_s1};
						end
						if (!do_finish) begin
							if (cur_cnt < hdr_last) begin
								n_cnt = cur_cnt + 4'd1;
							end else begin
								if (shortform)
									n_id = {n_id[23:0], 8'd0};
								if (n_size == 32'd0) begin
									do_finish  = 1'b1;
									fin_status = id3fw_pkg::ST_BAD_FRAME;
								end else if (n_size > {4'd0, n_tag_rem}) begin
									do_finish  = 1'b1;
									fin_status = id3fw_pkg::ST_TOO_BIG;
								end else begin
									n_frame_rem = n_size;
									n_frame_ff  = 1'b0;
									n_phase     = PH_PAYLOAD;
									res_valid   = 1'b1;
									res_kind    = id3fw_pkg::KIND_FRAME;
									res_id      = n_id;
									res_size    = n_size;
									res_flags   = n_flags;
								end
							end
						end
					end else if (!dropped) begin
						n_frame_rem = (cur_frame_rem != 32'd0) ? cur_frame_rem - 32'd1 : 32'd0;
						pay_last    = (n_frame_rem == 32'd0);
						if (cur_flags[id3fw_pkg::FRAME_FLAG_UNSYNC_BIT] && cur_frame_ff &&
							byte_s1 == 8'd0) begin
							n_frame_ff = 1'b0;
							if (pay_last) begin
								do_begin  = 1'b1;
								res_valid = 1'b1;
								res_kind  = id3fw_pkg::KIND_PAYLOAD;
								res_last  = 1'b1;
							end
						end else begin
							n_frame_ff = (byte_s1 == id3fw_pkg::SYNC_BYTE);
							do_begin   = pay_last;
							res_valid  = 1'b1;
							res_kind   = id3fw_pkg::KIND_PAYLOAD;
							res_size   = 32'd1;
							res_pay    = byte_s1;
							res_last   = pay_last;
						end
					end
				end
			end
			PH_IDLE: begin
			end
			default: begin
				n_phase = PH_IDLE;
			end
		endcase

		if (do_begin) begin
			n_phase = (cur_phase == PH_TAGHDR && n_tflags[id3fw_pkg::TAG_FLAG_EXT_BIT]) ?
				PH_EXTSIZE : PH_FRHDR;
			n_cnt   = 4'd0;
			n_id    = 32'd0;
			n_size  = 32'd0;
			n_flags = 16'd0;
		end
		if (do_finish) begin
			n_phase    = PH_IDLE;
			res_valid  = 1'b1;
			res_kind   = id3fw_pkg::KIND_STATUS;
			res_id     = 32'd0;
			res_size   = 32'd0;
			res_flags  = 16'd0;
			res_pay    = 8'd0;
			res_last   = 1'b0;
			res_status = fin_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= 4'd0;
			id_q        <= 32'd0;
			size_q      <= 32'd0;
			flags_q     <= 16'd0;
			ver_q       <= 8'd0;
			tflags_q    <= 8'd0;
			tag_rem_q   <= 28'd0;
			skip_q      <= 28'd0;
			frame_rem_q <= 32'd0;
			tag_ff_q    <= 1'b0;
			frame_ff_q  <= 1'b0;
		end else if (advance) begin
			phase_q     <= n_phase;
			cnt_q       <= n_cnt;
			id_q        <= n_id;
			size_q      <= n_size;
			flags_q     <= n_flags;
			ver_q       <= n_ver;
			tflags_q    <= n_tflags;
			tag_rem_q   <= n_tag_rem;
			skip_q      <= n_skip;
			frame_rem_q <= n_frame_rem;
			tag_ff_q    <= n_tag_ff;
			frame_ff_q  <= n_frame_ff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res_valid) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			kind_s2   <= res_kind;
			ver_s2    <= n_ver;
			id_s2     <= res_id;
			size_s2   <= res_size;
			flags_s2  <= res_flags;
			pay_s2    <= res_pay;
			last_s2   <= res_last;
			status_s2 <= res_status;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = kind_s2;
	assign m_axis_tlast  = last_s2;
	assign m_axis_tdata  = {5'd0, status_s2, pay_s2, flags_s2, size_s2, id_s2, ver_s2};

	`ID3FW_ASSERT_NEXT(a_status_ends_walk, clk, arst_n, advance && res_valid && res_kind == id3fw_pkg::KIND_STATUS, phase_q == PH_IDLE, "status result did not leave the walker idle")
	`ID3FW_ASSERT_NEXT(a_last_byte_to_header, clk, arst_n, advance && res_valid && res_kind == id3fw_pkg::KIND_PAYLOAD && res_last, phase_q == PH_FRHDR && cnt_q == 4'd0, "final payload byte did not return to frame header")
	`ID3FW_ASSERT(a_payload_count_live, clk, arst_n, phase_q != PH_PAYLOAD || frame_rem_q != 32'd0, "payload phase with no bytes left")
	`ID3FW_ASSERT(a_header_count_range, clk, arst_n, cnt_q < id3fw_pkg::LONG_HDR_LEN, "header byte index out of range")

endmodule
